// ===== sv/lrc_pkg.sv =====
// Package for the LRU result cache with pending jobs.
// Holds the result status codes, controller states and control/status structs.
// No dependencies.
package lrc_pkg;

	typedef enum logic [2:0] {
		ST_BOUND    = 3'd0,
		ST_PENDING  = 3'd1,
		ST_STARTED  = 3'd2,
		ST_REJECTED = 3'd3,
		ST_DONE     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_FILL
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic look;
		logic scan;
		logic fill;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} stat_t;

endpackage

// ===== sv/lru_result_cache_with_pending_jobs_unit.sv =====
// Top level of the LRU result cache with pending jobs.
// Joins lrc_ctrl (state machine) and lrc_dpath (slots, compare, scan); uses lrc_pkg.
//
// Usage:
//   Input channel: an item (action, key, done_slot) is taken at a rising edge with
//   start high and busy low. action 0 looks up key; action 1 marks done_slot ready if it is an in-use slot.
//   Result channel: exactly one result per item, shown for one cycle with
//   result_strobe high (status, slot, evicted). The receiver cannot stall it.
//   A done event, hit, fill of a free slot or rejection is decided in S_LOOK; its
//   result_strobe is registered from that decision. For such items busy is high
//   only in S_LOOK, so the next item can be taken once this one has been decided.
//   When a lookup misses, every slot is in use and some slot is ready, the oldest
//   ready slot is found by a scan over the stamp registers, one slot per cycle, then
//   replaced: such an item keeps busy high through S_LOOK, S_SCAN and S_FILL, and
//   its result_strobe rises at the same edge at which busy falls.
//   Reset (arst_n low) empties every slot, clears the ready marks and the use
//   counter; no clearing pass is needed, busy is low right after reset.
//   Only the low KEY_BITS bits of key are compared; the counter wraps at STAMP_BITS.
module lru_result_cache_with_pending_jobs_unit #(
	parameter int ENTRIES    = 8,
	parameter int KEY_BITS   = 64,
	parameter int STAMP_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [63:0] key,
	input  logic [2:0]  done_slot,
	output logic        result_strobe,
	output logic [2:0]  status,
	output logic [2:0]  slot,
	output logic        evicted
);

	lrc_pkg::cmd_t  cmd;
	lrc_pkg::stat_t stat;

	lrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	lrc_dpath #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.action        (action),
		.key           (key),
		.done_slot     (done_slot),
		.cmd           (cmd),
		.stat          (stat),
		.result_strobe (result_strobe),
		.status        (status),
		.slot          (slot),
		.evicted       (evicted)
	);

endmodule

// ===== sv/lrc_ctrl.sv =====
// Controller state machine of the LRU result cache.
// Sequences load, lookup, victim scan and victim fill; depends on lrc_pkg.
module lrc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lrc_pkg::stat_t stat,
	output lrc_pkg::cmd_t  cmd
);

	lrc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrc_pkg::S_IDLE: begin
				if (start) state_d = lrc_pkg::S_LOOK;
			end
			lrc_pkg::S_LOOK: begin
				state_d = stat.need_scan ? lrc_pkg::S_SCAN : lrc_pkg::S_IDLE;
			end
			lrc_pkg::S_SCAN: begin
				if (stat.scan_last) state_d = lrc_pkg::S_FILL;
			end
			lrc_pkg::S_FILL: begin
				state_d = lrc_pkg::S_IDLE;
			end
			default: begin
				state_d = lrc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		busy     = 1'b1;
		unique case (state_q)
			lrc_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			lrc_pkg::S_LOOK: cmd.look = 1'b1;
			lrc_pkg::S_SCAN: cmd.scan = 1'b1;
			lrc_pkg::S_FILL: cmd.fill = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

// ===== sv/lrc_dpath.sv =====
// Datapath of the LRU result cache: slot registers, parallel key compare,
// victim scan and result register. Driven by lrc_ctrl; depends on lrc_pkg.
module lrc_dpath #(
	parameter int ENTRIES    = 8,
	parameter int KEY_BITS   = 64,
	parameter int STAMP_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           action,
	input  logic [63:0]    key,
	input  logic [2:0]     done_slot,
	input  lrc_pkg::cmd_t  cmd,
	output lrc_pkg::stat_t stat,
	output logic           result_strobe,
	output logic [2:0]     status,
	output logic [2:0]     slot,
	output logic           evicted
);

	localparam int IW = $clog2(ENTRIES);

	// latched item
	logic                act_q;
	logic [KEY_BITS-1:0] key_q;
	logic [2:0]          dslot_q;

	// slot state
	logic [ENTRIES-1:0]    valid_q;
	logic [ENTRIES-1:0]    ready_q;
	logic [KEY_BITS-1:0]   key_mem_q   [ENTRIES];
	logic [STAMP_BITS-1:0] stamp_q     [ENTRIES];
	logic [STAMP_BITS-1:0] cnt_q;

	// victim scan
	logic [IW-1:0]         scan_idx_q;
	logic [IW-1:0]         best_idx_q;
	logic [STAMP_BITS-1:0] best_stamp_q;
	logic                  best_v_q;

	// result register
	lrc_pkg::status_t status_q;
	logic [2:0]       slot_q;
	logic             evicted_q;

	logic [ENTRIES-1:0]    hit_vec;
	logic                  hit_any;
	logic [IW-1:0]         hit_idx;
	logic                  free_any;
	logic [IW-1:0]         free_idx;
	logic                  ready_any;
	logic [STAMP_BITS-1:0] cnt_nxt;
	logic [IW-1:0]         done_idx;
	logic                  done_in_range;
	logic                  cand;

	logic                  res_we;
	lrc_pkg::status_t      res_status;
	logic [2:0]            res_slot;
	logic                  res_evict;
	logic                  fill_we;
	logic [IW-1:0]         fill_idx;
	logic                  stamp_we;
	logic [IW-1:0]         stamp_idx;
	logic [STAMP_BITS-1:0] stamp_val;
	logic                  ready_set;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_mem_q[i] == key_q);
		end
	end

	// lowest-numbered hit and lowest-numbered free slot
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = IW'(i);
			if (!valid_q[i]) free_idx = IW'(i);
		end
	end

	assign hit_any       = |hit_vec;
	assign free_any      = ~&valid_q;
	assign ready_any     = |ready_q;
	assign cnt_nxt       = cnt_q + STAMP_BITS'(1);
	assign done_in_range = 32'(dslot_q) < 32'(ENTRIES);
	assign done_idx      = IW'(dslot_q);

	assign cand = ready_q[scan_idx_q] && (!best_v_q || (stamp_q[scan_idx_q] < best_stamp_q));

	assign stat.need_scan = !act_q && !hit_any && !free_any && ready_any;
	assign stat.scan_last = (scan_idx_q == IW'(ENTRIES - 1));

	always_comb begin
		res_we     = 1'b0;
		res_status = lrc_pkg::ST_DONE;
		res_slot   = dslot_q;
		res_evict  = 1'b0;
		fill_we    = 1'b0;
		fill_idx   = free_idx;
		stamp_we   = 1'b0;
		stamp_idx  = hit_idx;
		stamp_val  = cnt_nxt;
		ready_set  = 1'b0;
		if (cmd.look) begin
			if (act_q) begin
				res_we    = 1'b1;
				ready_set = done_in_range && valid_q[done_idx];
			end else if (hit_any) begin
				res_we     = 1'b1;
				stamp_we   = 1'b1;
				res_status = ready_q[hit_idx] ? lrc_pkg::ST_BOUND : lrc_pkg::ST_PENDING;
				res_slot   = 3'(hit_idx);
			end else if (free_any) begin
				res_we     = 1'b1;
				fill_we    = 1'b1;
				stamp_we   = 1'b1;
				stamp_idx  = free_idx;
				res_status = lrc_pkg::ST_STARTED;
				res_slot   = 3'(free_idx);
			end else if (!ready_any) begin
				res_we     = 1'b1;
				res_status = lrc_pkg::ST_REJECTED;
				res_slot   = 3'd0;
			end
		end else if (cmd.fill) begin
			// counter already advanced during the lookup
			res_we     = 1'b1;
			fill_we    = 1'b1;
			fill_idx   = best_idx_q;
			stamp_we   = 1'b1;
			stamp_idx  = best_idx_q;
			stamp_val  = cnt_q;
			res_status = lrc_pkg::ST_STARTED;
			res_slot   = 3'(best_idx_q);
			res_evict  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			ready_q       <= '0;
			cnt_q         <= '0;
			best_v_q      <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= res_we;
			if (cmd.look && !act_q) cnt_q <= cnt_nxt;
			if (ready_set) ready_q[done_idx] <= 1'b1;
			if (fill_we) begin
				valid_q[fill_idx] <= 1'b1;
				ready_q[fill_idx] <= 1'b0;
			end
			if (cmd.look) begin
				best_v_q <= 1'b0;
			end else if (cmd.scan && cand) begin
				best_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action;
			key_q   <= key[KEY_BITS-1:0];
			dslot_q <= done_slot;
		end
		if (fill_we) key_mem_q[fill_idx] <= key_q;
		if (stamp_we) stamp_q[stamp_idx] <= stamp_val;
		if (cmd.look) begin
			scan_idx_q <= '0;
		end else if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + IW'(1);
			if (cand) begin
				best_idx_q   <= scan_idx_q;
				best_stamp_q <= stamp_q[scan_idx_q];
			end
		end
		if (res_we) begin
			status_q  <= res_status;
			slot_q    <= res_slot;
			evicted_q <= res_evict;
		end
	end

	assign status  = status_q;
	assign slot    = slot_q;
	assign evicted = evicted_q;

	a_ready_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_q & ~valid_q) == '0)
		else $error("ready slot that is not valid");

	a_fill_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> best_v_q)
		else $error("victim fill without a ready victim");

	a_evict_is_start: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && evicted_q) |-> (status_q == lrc_pkg::ST_STARTED))
		else $error("eviction reported on a result that started no job");

	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_strobe) |-> $past(cmd.look || cmd.fill))
		else $error("result strobe without lookup or fill");

endmodule
